// ----- sv/pba_pkg.sv -----
package pba_pkg;

   localparam int MAX_PAGES_DEF      = 4096;
   localparam int RESERVED_PAGES_DEF = 256;
   localparam logic [12:0] TOTAL_RESET = 13'd4096;
   localparam logic [12:0] COUNT_LIMIT = 13'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [11:0] page;
   } req_type;

   typedef struct packed {
      logic [11:0] page_number;
      logic        ok;
      logic [12:0] used_pages;
   } rsp_type;

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_SCAN     = 6'b000100,
      ST_FREE_RD  = 6'b001000,
      ST_FREE_CHK = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic scan;
      logic free_check;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic words_zero;
      logic hit;
      logic miss_last;
      logic out_free;
   } status_type;

endpackage

// ----- sv/page_bitmap_allocator.sv -----
// First-fit physical page allocator over a used-page bitmap of 32-bit words.
// After reset the block sweeps the bitmap RAM, one word per cycle, writing
// the reserved pages as used; req_ready stays low during the sweep, while
// CSR writes are taken as usual. An allocate request reads the bitmap
// words in order through the RAM's registered read port, one word per
// cycle, and grants the lowest free bit of the first word that is not
// full. Only complete words below total_pages are searched. A free request
// reads the bitmap word, then checks it and writes it back if the page is
// used and below total_pages. Each result loads the output register once
// that register is free, and the next request can be taken in the cycle
// after that load. One request is in work at a time; a finished response
// waits in the output register while the next request may already be
// accepted. used_pages is reported with every response.
module page_bitmap_allocator #(
   parameter int MAX_PAGES      = pba_pkg::MAX_PAGES_DEF,
   parameter int RESERVED_PAGES = pba_pkg::RESERVED_PAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  pba_pkg::req_type req_payload,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pba_pkg::rsp_type rsp_payload,
   // total_pages register
   input  logic             csr_wr_en,
   input  logic [12:0]      csr_wr_data
);
   import pba_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: clear sweep, scan, free read-modify-write, response hand-off
   pba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op   (req_payload.operation),
      .status   (status),
      .cmd      (cmd)
   );

   // bitmap RAM, scan pointers, used count, total register, output register
   pba_datapath #(
      .MAX_PAGES     (MAX_PAGES),
      .RESERVED_PAGES(RESERVED_PAGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .status     (status),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

// ----- sv/pba_ram.sv -----
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pba_ctrl.sv -----
module pba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  pba_pkg::status_type status,
   output pba_pkg::cmd_type    cmd
);
   import pba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_op == OP_FREE) begin
                  state_in = ST_FREE_RD;
               end else if (status.words_zero) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.miss_last) begin
               state_in = ST_RESP;
            end
         end
         ST_FREE_RD: begin
            state_in = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            cmd.free_check = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");

   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && status.hit |=> state_ff == ST_RESP)
      else $error("scan continued past a free bit");

   a_free_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FREE_CHK |-> $past(state_ff) == ST_FREE_RD)
      else $error("free check without bitmap read");

endmodule

// ----- sv/pba_datapath.sv -----
module pba_datapath #(
   parameter int MAX_PAGES      = pba_pkg::MAX_PAGES_DEF,
   parameter int RESERVED_PAGES = pba_pkg::RESERVED_PAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  pba_pkg::req_type    req_payload,
   input  pba_pkg::cmd_type    cmd,
   output pba_pkg::status_type status,
   input  logic                csr_wr_en,
   input  logic [12:0]         csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pba_pkg::rsp_type    rsp_payload
);
   import pba_pkg::*;

   localparam int WORD_COUNT = (MAX_PAGES + 31) / 32;
   localparam int FULL_WORDS = MAX_PAGES / 32;
   localparam int AW         = $clog2(WORD_COUNT);
   localparam int RSV        = (RESERVED_PAGES < MAX_PAGES) ? RESERVED_PAGES : MAX_PAGES;

   // reset image of one bitmap word: pages below RSV are used
   function automatic logic [31:0] reset_word(input logic [AW-1:0] w);
      logic [31:0] v;
      int          lo;
      lo = 32 * int'(w);
      for (int b = 0; b < 32; b++) begin
         v[b] = (lo + b) < RSV;
      end
      return v;
   endfunction

   logic [AW-1:0] clr_ff;
   logic [12:0]   total_ff;
   logic          op_ff;
   logic [11:0]   page_ff;
   logic [AW-1:0] issue_ff;
   logic [7:0]    check_ff;
   logic          dvld_ff;
   logic [12:0]   count_ff;
   logic [11:0]   res_page_ff;
   logic          res_ok_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [7:0]    words;
   logic [AW-1:0] page_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          full;
   logic          alloc_hit;
   logic [31:0]   low_mask;
   logic [4:0]    low_idx;
   logic [31:0]   free_mask;
   logic          in_range;
   logic          free_ok;

   // searchable words: complete words below the managed total
   always_comb begin
      if (32'(total_ff[12:5]) > FULL_WORDS) begin
         words = 8'(FULL_WORDS);
      end else begin
         words = total_ff[12:5];
      end
   end

   assign page_addr = AW'(32'(page_ff[11:5]));
   assign rd_addr   = cmd.scan ? issue_ff : page_addr;

   assign full      = &rd_data;
   assign alloc_hit = cmd.scan && dvld_ff && !full;

   // lowest clear bit as a one-hot mask
   assign low_mask = ~rd_data & (rd_data + 32'd1);

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (low_mask[i]) begin
            low_idx = low_idx | 5'(i);
         end
      end
   end

   assign free_mask = 32'd1 << page_ff[4:0];
   assign in_range  = ({1'b0, page_ff} < total_ff) && (32'(page_ff) < MAX_PAGES);
   assign free_ok   = in_range && ((rd_data & free_mask) != '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = page_addr;
      wr_data = rd_data & ~free_mask;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = reset_word(clr_ff);
      end else if (alloc_hit) begin
         wr_en   = 1'b1;
         wr_addr = AW'(32'(check_ff));
         wr_data = rd_data | low_mask;
      end else if (cmd.free_check && free_ok) begin
         wr_en = 1'b1;
      end
   end

   pba_ram #(
      .WIDTH(32),
      .DEPTH(WORD_COUNT)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         total_ff     <= TOTAL_RESET;
         count_ff     <= 13'(RSV);
         rsp_valid_ff <= 1'b0;
         dvld_ff      <= 1'b0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (alloc_hit) begin
            count_ff <= count_ff + 13'd1;
         end else if (cmd.free_check && free_ok && count_ff != '0) begin
            count_ff <= count_ff - 13'd1;
         end
         if (cmd.accept) begin
            dvld_ff <= 1'b0;
         end else if (cmd.scan) begin
            dvld_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan pointers: issue runs one word ahead of the word being checked
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_payload.operation;
         page_ff     <= req_payload.page;
         issue_ff    <= '0;
         check_ff    <= '0;
         res_page_ff <= '0;
         res_ok_ff   <= 1'b0;
      end else begin
         if (cmd.scan) begin
            issue_ff <= issue_ff + 1'b1;
            if (dvld_ff) begin
               check_ff <= check_ff + 8'd1;
            end
         end
         if (alloc_hit) begin
            res_page_ff <= {check_ff[6:0], low_idx};
            res_ok_ff   <= 1'b1;
         end else if (cmd.free_check) begin
            res_ok_ff <= free_ok;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.page_number <= res_page_ff;
         rsp_ff.ok          <= res_ok_ff;
         rsp_ff.used_pages  <= count_ff;
      end
   end

   assign status.clear_last = clr_ff == AW'(WORD_COUNT - 1);
   assign status.words_zero = words == '0;
   assign status.hit        = dvld_ff && !full;
   assign status.miss_last  = dvld_ff && full && (check_ff == words - 8'd1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_free_page_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp && op_ff == OP_FREE |-> res_page_ff == '0)
      else $error("free result carries a page number");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("used count out of range");

   a_hit_in_window: assert property (@(posedge clock) disable iff (reset)
      alloc_hit |-> check_ff < words)
      else $error("allocation outside searchable words");

endmodule

// ----- dv/page_bitmap_allocator_checker.sv -----
module page_bitmap_allocator_checker
   import pba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          error_count,
   output int          pending_count,
   output int          granted_count,
   output int          refused_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORDS = MAX_PAGES_DEF / 32;

   logic [31:0] shadow_bitmap [WORDS];
   logic [12:0] shadow_used;
   logic [12:0] shadow_total;
   rsp_type     owed_rsp [$];
   int          mismatch_total;
   int          grants;
   int          refusals;

   initial begin
      error_count    = 0;
      pending_count  = 0;
      granted_count  = 0;
      refused_count  = 0;
      mismatch_total = 0;
      grants         = 0;
      refusals       = 0;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatch_total < 20) begin
         $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      end
      mismatch_total++;
   endtask

   // first fit over complete words below the total; free only a used page below it
   function automatic rsp_type predict_page_op(input req_type r);
      rsp_type     res;
      logic [12:0] limit;
      int          words;
      logic        found;
      res   = '0;
      limit = (shadow_total > COUNT_LIMIT) ? COUNT_LIMIT : shadow_total;
      if (r.operation == OP_ALLOC) begin
         words = int'(limit) / 32;
         found = 1'b0;
         for (int w = 0; w < words && w < WORDS && !found; w++) begin
            if (shadow_bitmap[w] != 32'hFFFF_FFFF) begin
               for (int b = 0; b < 32 && !found; b++) begin
                  if (!shadow_bitmap[w][b]) begin
                     shadow_bitmap[w][b] = 1'b1;
                     shadow_used         = shadow_used + 13'd1;
                     res.page_number     = 12'(w * 32 + b);
                     res.ok              = 1'b1;
                     found               = 1'b1;
                  end
               end
            end
         end
      end else if ({1'b0, r.page} < limit && shadow_bitmap[r.page[11:5]][r.page[4:0]]) begin
         shadow_bitmap[r.page[11:5]][r.page[4:0]] = 1'b0;
         if (shadow_used != 13'd0) begin
            shadow_used = shadow_used - 13'd1;
         end
         res.ok = 1'b1;
      end
      res.used_pages = shadow_used;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int w = 0; w < WORDS; w++) begin
            shadow_bitmap[w] = '0;
         end
         shadow_used = '0;
         for (int p = 0; p < RESERVED_PAGES_DEF && p < MAX_PAGES_DEF; p++) begin
            shadow_bitmap[p / 32][p % 32] = 1'b1;
            shadow_used = shadow_used + 13'd1;
         end
         shadow_total = TOTAL_RESET;
         owed_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            shadow_total = csr_wr_data;
         end
         // the response leaving now always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               flag_mismatch("response with none owed, page_number",
                             int'(rsp_payload.page_number), 0);
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_payload.page_number !== want.page_number) begin
                  flag_mismatch("page_number", int'(rsp_payload.page_number),
                                int'(want.page_number));
               end
               if (rsp_payload.ok !== want.ok) begin
                  flag_mismatch("ok", int'(rsp_payload.ok), int'(want.ok));
               end
               if (rsp_payload.used_pages !== want.used_pages) begin
                  flag_mismatch("used_pages", int'(rsp_payload.used_pages),
                                int'(want.used_pages));
               end
               if (want.ok) grants++;
               else refusals++;
            end
         end
         if (req_valid && req_ready) begin
            owed_rsp.push_back(predict_page_op(req_payload));
         end
      end
      error_count   <= mismatch_total;
      pending_count <= owed_rsp.size();
      granted_count <= grants;
      refused_count <= refusals;
   end

endmodule

// ----- dv/page_bitmap_allocator_tb.sv -----
module page_bitmap_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import pba_pkg::*;

   localparam int RANDOM_ITEMS  = 1200;
   localparam int LONG_HOLD     = 600;   // receiver stall, well past one alloc scan
   localparam int IDLE_LIMIT    = 4000;  // cycles with no handshake before giving up

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [12:0] csr_wr_data = '0;

   int error_count;
   int pending_count;
   int granted_count;
   int refused_count;

   // stimulus bookkeeping
   int          sent_count  = 0;
   int          cfg_writes  = 0;
   int          burst_left  = 0;
   int          net_alloc   = 0;   // rough high-water estimate for aiming frees
   int          total_now   = 4096;
   int          hold_asked  = 0;   // bumped by stimulus, served by the receiver
   int          hold_done   = 0;
   int          idle_cycles = 0;

   page_bitmap_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   page_bitmap_allocator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .granted_count (granted_count),
      .refused_count (refused_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hang shows up as a long run of cycles with no handshake.
   // The worst legal stretch is the long receiver hold plus one full scan.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  IDLE_LIMIT, pending_count);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: switches between stall patterns, each held for a random span.
   // A hold asked by the stimulus keeps ready low so the block backs up with
   // one response parked and one request in work.
   initial begin
      int mode;
      int span;
      int tick;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(posedge clock);
            tick++;
            if (hold_asked != hold_done) begin
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
               hold_done++;
            end
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 7) != 0);
               end
               default: begin
                  rsp_ready <= ((tick % 5) < 2);
               end
            endcase
         end
      end
   end

   // Offer one request and hold it until accepted. Requests go out in bursts;
   // at the end of a burst valid drops for a gap before the next burst.
   task automatic issue(input req_type r);
      int gap;
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         // some long gapless bursts, mostly short ones
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic do_alloc();
      req_type r;
      r.operation = OP_ALLOC;
      r.page      = 12'($urandom_range(0, 4095));   // don't-care field, keep it moving
      net_alloc++;
      issue(r);
   endtask

   task automatic do_free(input logic [11:0] pg);
      req_type r;
      r.operation = OP_FREE;
      r.page      = pg;
      if (net_alloc > 0) net_alloc--;
      issue(r);
   endtask

   // Stop offering and wait until every response is back; pending_count is
   // a registered copy of the checker's queue size.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // total_pages is only written with the block idle
   task automatic set_total(input logic [12:0] v);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_writes++;
      total_now = int'(v);
   endtask

   initial begin
      int phase;
      int alloc_pct;
      int n;
      int lim;
      int hi;
      int pick;
      int target;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // default total: first grants land right after the reserved pages
      set_total(13'd4096);
      do_alloc();                 // 256
      do_alloc();                 // 257
      do_free(12'd256);
      do_free(12'd256);           // already free, ignored
      do_alloc();                 // 256 again
      do_free(12'd0);             // reserved page can be freed
      do_alloc();                 // 0 again
      do_free(12'd4095);          // never used, ignored
      do_alloc();

      // trailing partial word is never granted: all complete words are full
      set_total(13'd264);
      do_alloc();
      do_free(12'd257);
      do_free(12'd263);
      do_alloc();

      // used page sitting at the total cannot be freed
      set_total(13'd256);
      do_free(12'd256);

      // zero total: nothing at all
      set_total(13'd0);
      do_alloc();
      do_free(12'd0);

      // below one word: free works, allocate still fails
      set_total(13'd31);
      do_free(12'd3);
      do_alloc();

      // register above MAX_PAGES acts as MAX_PAGES; bitmap kept across the change
      set_total(13'd8191);
      do_alloc();                 // 3
      do_free(12'd4095);
      do_alloc();
      do_free(12'd2048);

      // ---- random part ----
      phase  = 0;
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         case ($urandom_range(0, 7))
            0: set_total(13'd4096);
            1: set_total(13'd8191);
            2: set_total(13'($urandom_range(0, 8191)));
            3: set_total(13'(256 + 32 * $urandom_range(0, 4) + $urandom_range(0, 31)));
            4: set_total(13'($urandom_range(0, 40)));
            5: set_total(13'($urandom_range(4097, 8190)));
            6: set_total(13'd288);
            default: set_total(13'($urandom_range(256, 1200)));
         endcase
         // fill-heavy, balanced, or drain-heavy
         case ($urandom_range(0, 2))
            0: alloc_pct = 85;
            1: alloc_pct = 50;
            default: alloc_pct = 20;
         endcase
         // long receiver hold while requests keep coming
         if (phase % 6 == 1) begin
            hold_asked <= hold_asked + 1;
         end
         n = $urandom_range(30, 120);
         lim = (total_now > 4096) ? 4096 : total_now;
         repeat (n) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
               do_alloc();
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 60) begin
                  // aim at the region first fit has been filling
                  hi = 256 + net_alloc;
                  if (hi > lim) hi = lim;
                  hi = hi - 1;
                  if (hi > 4095) hi = 4095;
                  if (hi < 0) hi = 0;
                  do_free(12'($urandom_range(0, hi)));
               end else if (pick < 85) begin
                  do_free(12'($urandom_range(0, 4095)));
               end else begin
                  do_free(12'($urandom_range(0, 255)));
               end
            end
         end
         phase++;
      end

      // ---- wrap up ----
      wait_drained();
      repeat (20) @(posedge clock);

      $display("ran %0d requests across %0d total_pages writes, %0d long response holds",
               sent_count, cfg_writes, hold_done);
      $display("responses: %0d granted or freed, %0d refused or ignored",
               granted_count, refused_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
